[rtl/bir_pkg.sv]
// Shared types and constants of the bilinear image scaler.
// Used by the divider pipeline and the top level; depends on nothing.
package bir_pkg;

  localparam int COORD_W   = 10;  // row and column of an input beat
  localparam int DST_W     = 11;  // output size registers
  localparam int SRC_W     = 8;   // source size registers
  localparam int CH_W      = 3;   // channel count register
  localparam int FRAC_W    = 16;  // Q.16 position fraction
  localparam int PIX_W     = 32;  // packed pixel
  localparam int PIX_LANES = 4;   // 8-bit channels in a packed pixel
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_HEIGHT    = 3'd0,
    CFG_SRC_WIDTH     = 3'd1,
    CFG_DST_HEIGHT    = 3'd2,
    CFG_DST_WIDTH     = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_COMPUTE = 1'b1
  } req_e;

endpackage

[rtl/bir_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package needed.
module bir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bir_div.sv]
// Pipelined restoring divider: quotient of (prod << 16) / dvs, one bit per stage.
// Depends on bir_pkg for the coordinate, size and fraction widths.
module bir_div #(
  parameter int SW = 8
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [bir_pkg::COORD_W+SW-1:0]   prod_i,
  input  logic [bir_pkg::DST_W-1:0]        dvs_i,
  output logic [SW+bir_pkg::FRAC_W-1:0]    quo_o
);
  import bir_pkg::*;

  localparam int QW = SW + FRAC_W;

  logic [DST_W-1:0] rem_s [QW+1];
  logic [QW-1:0]    quo_s [QW+1];
  logic [SW-1:0]    low_s [QW+1];
  logic [DST_W-1:0] dvs_s [QW+1];

  // The upper product bits form the first partial remainder; it is below the
  // divisor whenever the coordinate is inside the output size.
  assign rem_s[0] = DST_W'(prod_i[COORD_W+SW-1:SW]);
  assign quo_s[0] = '0;
  assign low_s[0] = prod_i[SW-1:0];
  assign dvs_s[0] = dvs_i;

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BI = QW - 1 - k;
    logic             nb;
    logic [DST_W:0]   rem2;
    logic             ge;
    logic [DST_W-1:0] rem_q;
    logic [QW-1:0]    quo_q;
    logic [SW-1:0]    low_q;
    logic [DST_W-1:0] dvs_q;

    if (BI >= FRAC_W) begin : g_bit
      assign nb = low_s[k][BI-FRAC_W];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign rem2 = {rem_s[k], nb};
    assign ge   = rem2 >= {1'b0, dvs_s[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? DST_W'(rem2 - {1'b0, dvs_s[k]}) : DST_W'(rem2);
        quo_q <= {quo_s[k][QW-2:0], ge};
        low_q <= low_s[k];
        dvs_q <= dvs_s[k];
      end
    end

    assign rem_s[k+1] = rem_q;
    assign quo_s[k+1] = quo_q;
    assign low_s[k+1] = low_q;
    assign dvs_s[k+1] = dvs_q;
  end

  assign quo_o = quo_s[QW];

endmodule

[rtl/bilinear_image_resize.sv]
// Bilinear image scaler: frame store in four parity banks, pipelined position
// divider and blend pipeline. Depends on bir_pkg, bir_div and bir_ram.
//
//  channel | valid      | stall         | payload
//  --------+------------+---------------+--------------------------------------
//  input   | in_valid_i | in_stall_o    | req_type_i row_i col_i pixel_in_i
//  output  | out_valid_o| out_stall_i   | pixel_out_o out_of_range_o
//  config  | cfg_we_i   | (none)        | cfg_idx_i cfg_data_i
//
// One beat enters per cycle while in_stall_o is low. A compute beat passes
// stage 0, the one-bit-per-stage position divider, the store read and stages
// B to E before the output register. Loads write the store at the same
// stage where computes read it, so order is kept. The whole pipeline holds
// while a result waits under stall. Reset clears valid bits and the config
// registers; the frame store is not cleared.
module bilinear_image_resize #(
  parameter int MAX_SRC_DIM  = 128,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bir_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [bir_pkg::COORD_W-1:0]    row_i,
  input  logic [bir_pkg::COORD_W-1:0]    col_i,
  input  logic [bir_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bir_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                           out_of_range_o
);
  import bir_pkg::*;

  localparam int SW   = $clog2(MAX_SRC_DIM + 1);
  localparam int IW   = $clog2(MAX_SRC_DIM);
  localparam int PW   = COORD_W + SW;
  localparam int QW   = SW + FRAC_W;
  localparam int HALF = (MAX_SRC_DIM + 1) / 2;
  localparam int BD   = HALF * HALF;
  localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int CAP  = (MAX_CHANNELS < PIX_LANES) ? MAX_CHANNELS : PIX_LANES;
  localparam int WW   = FRAC_W + 1;
  localparam int HW   = 8 + WW;
  localparam int VW   = HW + WW;

  typedef struct packed {
    logic            cmp;
    logic            oor;
    logic            ok;
    logic [PIX_W-1:0] pix;
    logic [IW-1:0]   r;
    logic [IW-1:0]   c;
  } side_t;

  // Configuration registers.
  logic [SRC_W-1:0] src_h_q, src_w_q;
  logic [DST_W-1:0] dst_h_q, dst_w_q;
  logic [CH_W-1:0]  ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_h_q <= SRC_W'(128);
      src_w_q <= SRC_W'(128);
      dst_h_q <= DST_W'(128);
      dst_w_q <= DST_W'(128);
      ch_q    <= CH_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SRC_HEIGHT:    src_h_q <= cfg_data_i[SRC_W-1:0];
        CFG_SRC_WIDTH:     src_w_q <= cfg_data_i[SRC_W-1:0];
        CFG_DST_HEIGHT:    dst_h_q <= cfg_data_i;
        CFG_DST_WIDTH:     dst_w_q <= cfg_data_i;
        CFG_CHANNEL_COUNT: ch_q    <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0]   sh, sw;
  logic [CH_W-1:0] nch;

  always_comb begin
    if (src_h_q == '0) begin
      sh = SW'(1);
    end else if (int'(src_h_q) > MAX_SRC_DIM) begin
      sh = SW'(MAX_SRC_DIM);
    end else begin
      sh = SW'(src_h_q);
    end
    if (src_w_q == '0) begin
      sw = SW'(1);
    end else if (int'(src_w_q) > MAX_SRC_DIM) begin
      sw = SW'(MAX_SRC_DIM);
    end else begin
      sw = SW'(src_w_q);
    end
    nch = (int'(ch_q) > CAP) ? CH_W'(CAP) : ch_q;
  end

  // The pipeline moves as one unless a finished result is held back.
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 0: capture, range checks and the position products.
  logic          v_s  [QW+1];
  side_t         sd_s [QW+1];
  logic          v0_q;
  side_t         sd0_q;
  logic [PW-1:0] prod_y_q, prod_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd0_q.cmp <= req_e'(req_type_i) == REQ_COMPUTE;
      sd0_q.oor <= ({1'b0, row_i} >= dst_h_q) || ({1'b0, col_i} >= dst_w_q);
      sd0_q.ok  <= (int'(row_i) < MAX_SRC_DIM) && (int'(col_i) < MAX_SRC_DIM);
      sd0_q.pix <= pixel_in_i;
      sd0_q.r   <= row_i[IW-1:0];
      sd0_q.c   <= col_i[IW-1:0];
      prod_y_q  <= PW'(row_i) * PW'(sh);
      prod_x_q  <= PW'(col_i) * PW'(sw);
    end
  end

  assign v_s[0]  = v0_q;
  assign sd_s[0] = sd0_q;

  // Side data travels alongside the divider stages.
  for (genvar k = 0; k < QW; k++) begin : g_side
    logic  v_q;
    side_t sd_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv) begin
        v_q <= v_s[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_q <= sd_s[k];
      end
    end
    assign v_s[k+1]  = v_q;
    assign sd_s[k+1] = sd_q;
  end

  logic [QW-1:0] quo_y, quo_x;

  bir_div #(.SW(SW)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .prod_i (prod_y_q),
    .dvs_i  (dst_h_q),
    .quo_o  (quo_y)
  );

  bir_div #(.SW(SW)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .prod_i (prod_x_q),
    .dvs_i  (dst_w_q),
    .quo_o  (quo_x)
  );

  // Address stage: integer part picks the top-left neighbor; each of the four
  // neighbors falls in a different row/column parity bank.
  side_t             sa;
  logic              va;
  logic [SW-1:0]     yi, xi;
  logic [IW-1:0]     ya, xa;
  logic              lrow_a, lcol_a;
  logic [1:0]        bank_ld;
  logic [BAW-1:0]    waddr;
  logic [BAW-1:0]    raddr [4];
  logic [PIX_W-1:0]  rdata [4];

  assign sa      = sd_s[QW];
  assign va      = v_s[QW];
  assign yi      = quo_y[QW-1:FRAC_W];
  assign xi      = quo_x[QW-1:FRAC_W];
  assign ya      = yi[IW-1:0];
  assign xa      = xi[IW-1:0];
  assign lrow_a  = yi == SW'(sh - 1'b1);
  assign lcol_a  = xi == SW'(sw - 1'b1);
  assign bank_ld = {sa.r[0], sa.c[0]};
  assign waddr   = BAW'(int'(sa.r >> 1) * HALF + int'(sa.c >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int RP = b / 2;
    localparam int CP = b % 2;
    logic [IW-1:0] rh, chf;
    logic          we;
    assign rh  = (ya >> 1) + IW'(ya[0] & (RP == 0));
    assign chf = (xa >> 1) + IW'(xa[0] & (CP == 0));
    assign raddr[b] = BAW'(int'(rh) * HALF + int'(chf));
    assign we = adv && va && !sa.cmp && sa.ok && (bank_ld == 2'(b));

    bir_ram #(.WIDTH(PIX_W), .DEPTH(BD)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (sa.pix),
      .re_i    (adv),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  // Stage B: store data arrives. Edge cases zero the unused weight.
  logic              vb_q, cmpb_q, oorb_q, pyb_q, pxb_q, lrowb_q, lcolb_q;
  logic [FRAC_W-1:0] fyb_q, fxb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmpb_q  <= sa.cmp;
      oorb_q  <= sa.oor;
      pyb_q   <= ya[0];
      pxb_q   <= xa[0];
      lrowb_q <= lrow_a;
      lcolb_q <= lcol_a;
      fyb_q   <= lrow_a ? '0 : quo_y[FRAC_W-1:0];
      fxb_q   <= lcol_a ? '0 : quo_x[FRAC_W-1:0];
    end
  end

  logic [PIX_W-1:0] p00, p01, p10, p11;
  logic [WW-1:0]    wx0, wx1;
  logic [HW-1:0]    h_d [PIX_LANES][4];

  assign p00 = rdata[{pyb_q, pxb_q}];
  assign p01 = lcolb_q ? '0 : rdata[{pyb_q, ~pxb_q}];
  assign p10 = lrowb_q ? '0 : rdata[{~pyb_q, pxb_q}];
  assign p11 = (lrowb_q || lcolb_q) ? '0 : rdata[{~pyb_q, ~pxb_q}];
  assign wx0 = WW'(1 << FRAC_W) - WW'(fxb_q);
  assign wx1 = WW'(fxb_q);

  always_comb begin
    for (int k = 0; k < PIX_LANES; k++) begin
      h_d[k][0] = HW'(p00[8*k +: 8]) * HW'(wx0);
      h_d[k][1] = HW'(p01[8*k +: 8]) * HW'(wx1);
      h_d[k][2] = HW'(p10[8*k +: 8]) * HW'(wx0);
      h_d[k][3] = HW'(p11[8*k +: 8]) * HW'(wx1);
    end
  end

  // Stage C: horizontal products.
  logic              vc_q, cmpc_q, oorc_q;
  logic [FRAC_W-1:0] fyc_q;
  logic [HW-1:0]     h_q [PIX_LANES][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmpc_q <= cmpb_q;
      oorc_q <= oorb_q;
      fyc_q  <= fyb_q;
      h_q    <= h_d;
    end
  end

  // Stage D: top and bottom row blends.
  logic              vd_q, cmpd_q, oord_q;
  logic [FRAC_W-1:0] fyd_q;
  logic [HW-1:0]     top_q [PIX_LANES];
  logic [HW-1:0]     bot_q [PIX_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmpd_q <= cmpc_q;
      oord_q <= oorc_q;
      fyd_q  <= fyc_q;
      for (int k = 0; k < PIX_LANES; k++) begin
        top_q[k] <= h_q[k][0] + h_q[k][1];
        bot_q[k] <= h_q[k][2] + h_q[k][3];
      end
    end
  end

  // Stage E: vertical products.
  logic          ve_q, cmpe_q, oore_q;
  logic [WW-1:0] wy0, wy1;
  logic [VW-1:0] vt_q [PIX_LANES];
  logic [VW-1:0] vbt_q [PIX_LANES];

  assign wy0 = WW'(1 << FRAC_W) - WW'(fyd_q);
  assign wy1 = WW'(fyd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (adv) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmpe_q <= cmpd_q;
      oore_q <= oord_q;
      for (int k = 0; k < PIX_LANES; k++) begin
        vt_q[k]  <= VW'(top_q[k]) * VW'(wy0);
        vbt_q[k] <= VW'(bot_q[k]) * VW'(wy1);
      end
    end
  end

  // Output register: sum, take the integer byte, mask unused channels and out-of-range results.
  logic [PIX_W-1:0] pix_d, pix_q;
  logic             oor_q;
  logic [VW-1:0]    vsum [PIX_LANES];

  always_comb begin
    pix_d = '0;
    for (int k = 0; k < PIX_LANES; k++) begin
      vsum[k] = vt_q[k] + vbt_q[k];
      if (!oore_q && (CH_W'(k) < nch)) begin
        pix_d[8*k +: 8] = vsum[k][2*FRAC_W +: 8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ve_q && cmpe_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q <= pix_d;
      oor_q <= oore_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pix_q;
  assign out_of_range_o = oor_q;

endmodule

[sim/bilinear_image_resize_test.sv]
// Self-checking testbench of the bilinear image scaler: loads update a mirror and compute
// results are predicted in the bench and checked per beat. Depends on bir_pkg and the RTL.
`timescale 1ns / 100ps

module bilinear_image_resize_test;
  import bir_pkg::*;

  localparam int STORE_DIM = 128;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             oor;
  } resized_px_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i = 1'b0;
  logic [COORD_W-1:0]   row_i = '0;
  logic [COORD_W-1:0]   col_i = '0;
  logic [PIX_W-1:0]     pixel_in_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 out_of_range_o;

  // Mirror of the block's registers and frame store.
  logic [SRC_W-1:0]   src_h_q;
  logic [SRC_W-1:0]   src_w_q;
  logic [DST_W-1:0]   dst_h_q;
  logic [DST_W-1:0]   dst_w_q;
  logic [CH_W-1:0]    chans_q;
  logic [PIX_W-1:0]   store_mirror [STORE_DIM*STORE_DIM];
  bit                 store_written [STORE_DIM*STORE_DIM];
  resized_px_t        pending_px [$];
  bit                 idling_on;
  int                 mismatches;
  int                 stall_left;

  bilinear_image_resize dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (!idling_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned eff_src(logic [SRC_W-1:0] v);
    if (v == 0) return 1;
    if (v > STORE_DIM) return STORE_DIM;
    return v;
  endfunction

  // Output coordinate to source index and Q.16 weight, clamped to the last index.
  function automatic void map_axis(input int unsigned o, input int unsigned s,
                                   input int unsigned d, output int unsigned idx,
                                   output int unsigned frac);
    logic [63:0] pos;
    pos = ((64'(o) * 64'(s)) << FRAC_W) / 64'(d);
    if ((pos >> FRAC_W) > 64'(s - 1)) begin
      idx = s - 1;
      frac = 0;
    end else begin
      idx = int'(pos >> FRAC_W);
      frac = int'(pos[FRAC_W-1:0]);
    end
  endfunction

  function automatic resized_px_t resize_px(int unsigned r, int unsigned c);
    resized_px_t res;
    int unsigned sh, sw, nch, y1, x1, fy, fx;
    bit lr, lc;
    logic [PIX_W-1:0] p00, p01, p10, p11;
    logic [63:0] top, bot, v;
    res = '0;
    if (r >= dst_h_q || c >= dst_w_q) begin
      res.oor = 1'b1;
      return res;
    end
    sh = eff_src(src_h_q);
    sw = eff_src(src_w_q);
    nch = (chans_q > PIX_LANES) ? PIX_LANES : chans_q;
    map_axis(r, sh, dst_h_q, y1, fy);
    map_axis(c, sw, dst_w_q, x1, fx);
    lr = (y1 == sh - 1);
    lc = (x1 == sw - 1);
    p00 = store_mirror[y1*STORE_DIM + x1];
    p01 = lc ? '0 : store_mirror[y1*STORE_DIM + x1 + 1];
    p10 = lr ? '0 : store_mirror[(y1+1)*STORE_DIM + x1];
    p11 = (lr || lc) ? '0 : store_mirror[(y1+1)*STORE_DIM + x1 + 1];
    for (int k = 0; k < nch; k++) begin
      if (lr && lc) begin
        v = 64'(p00[8*k +: 8]);
      end else if (lc) begin
        v = (64'(p00[8*k +: 8]) * (65536 - fy) + 64'(p10[8*k +: 8]) * fy) >> 16;
      end else if (lr) begin
        v = (64'(p00[8*k +: 8]) * (65536 - fx) + 64'(p01[8*k +: 8]) * fx) >> 16;
      end else begin
        top = 64'(p00[8*k +: 8]) * (65536 - fx) + 64'(p01[8*k +: 8]) * fx;
        bot = 64'(p10[8*k +: 8]) * (65536 - fx) + 64'(p11[8*k +: 8]) * fx;
        v = (top * (65536 - fy) + bot * fy) >> 32;
      end
      res.pixel[8*k +: 8] = v[7:0];
    end
    return res;
  endfunction

  // Drives one input beat; once accepted, updates the mirror for a load or queues the expected result.
  task automatic send_beat(req_e req, int unsigned r, int unsigned c,
                           logic [PIX_W-1:0] pix);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    row_i <= r[COORD_W-1:0];
    col_i <= c[COORD_W-1:0];
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    if (req == REQ_LOAD) begin
      if (r < STORE_DIM && c < STORE_DIM) begin
        store_mirror[r*STORE_DIM + c] = pix;
        store_written[r*STORE_DIM + c] = 1'b1;
      end
    end else begin
      pending_px = {pending_px, resize_px(r, c)};
    end
    @(negedge clk_i);
  endtask

  task automatic ensure_loaded(int unsigned r, int unsigned c);
    if (!store_written[r*STORE_DIM + c]) send_beat(REQ_LOAD, r, c, $urandom());
  endtask

  // Loads any neighbor never written before it asks for the output pixel.
  task automatic send_compute(int unsigned r, int unsigned c);
    int unsigned sh, sw, y1, x1, fy, fx;
    if (r < dst_h_q && c < dst_w_q) begin
      sh = eff_src(src_h_q);
      sw = eff_src(src_w_q);
      map_axis(r, sh, dst_h_q, y1, fy);
      map_axis(c, sw, dst_w_q, x1, fx);
      ensure_loaded(y1, x1);
      if (x1 != sw - 1) ensure_loaded(y1, x1 + 1);
      if (y1 != sh - 1) ensure_loaded(y1 + 1, x1);
      if (x1 != sw - 1 && y1 != sh - 1) ensure_loaded(y1 + 1, x1 + 1);
    end
    send_beat(REQ_COMPUTE, r, c, $urandom());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DAT_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SRC_HEIGHT:    src_h_q = val[SRC_W-1:0];
      CFG_SRC_WIDTH:     src_w_q = val[SRC_W-1:0];
      CFG_DST_HEIGHT:    dst_h_q = val[DST_W-1:0];
      CFG_DST_WIDTH:     dst_w_q = val[DST_W-1:0];
      CFG_CHANNEL_COUNT: chans_q = val[CH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned sh, int unsigned sw, int unsigned dh,
                              int unsigned dw, int unsigned ch);
    drain();
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_CHANNEL_COUNT, ch);
  endtask

  // Mostly in-range computes, some past the output size, some loads.
  task automatic random_beats(int n);
    int unsigned r, c, lim_r, lim_c;
    for (int i = 0; i < n; i++) begin
      lim_r = (dst_h_q == 0) ? 3 : ((dst_h_q + 2 > 1023) ? 1023 : dst_h_q + 2);
      lim_c = (dst_w_q == 0) ? 3 : ((dst_w_q + 2 > 1023) ? 1023 : dst_w_q + 2);
      case ($urandom_range(19))
        0, 1, 2: send_beat(REQ_LOAD, $urandom_range(STORE_DIM - 1),
                           $urandom_range(STORE_DIM - 1), $urandom());
        3: begin
          send_beat(REQ_LOAD, $urandom_range(1023), $urandom_range(1023), $urandom());
          i--;
        end
        4: send_compute($urandom_range(1023), $urandom_range(1023));
        default: begin
          r = $urandom_range(lim_r);
          c = $urandom_range(lim_c);
          send_compute(r, c);
        end
      endcase
    end
  endtask

  task automatic test_reset_geometry();
    idling_on = 1'b0;
    send_beat(REQ_LOAD, 0, 0, 32'hFFFF_FFFF);
    send_beat(REQ_LOAD, 0, 1, 32'h0000_0000);
    send_beat(REQ_LOAD, 1, 0, 32'h0000_0000);
    send_beat(REQ_LOAD, 1, 1, 32'hFFFF_FFFF);
    send_compute(0, 0);
    send_compute(127, 127);
    send_compute(127, 0);
    send_compute(0, 127);
    send_compute(64, 63);
    send_compute(128, 0);
    send_compute(0, 128);
    send_compute(1023, 1023);
    // A load outside the store must be dropped.
    send_beat(REQ_LOAD, 1023, 5, 32'hDEAD_BEEF);
    send_beat(REQ_LOAD, 5, 1023, 32'hDEAD_BEEF);
    send_compute(1, 0);
  endtask

  task automatic test_register_extremes();
    idling_on = 1'b1;
    set_geometry(1, 1, 1, 1, 1);
    send_compute(0, 0);
    send_compute(1, 0);
    random_beats(40);
    set_geometry(128, 128, 1024, 1024, 4);
    send_compute(1023, 1023);
    send_compute(0, 1023);
    random_beats(80);
    set_geometry(0, 255, 2047, 0, 7);
    random_beats(40);
    set_geometry(255, 0, 5, 2047, 0);
    random_beats(40);
    set_geometry(128, 2, 1, 1024, 2);
    random_beats(60);
    set_geometry(3, 128, 1000, 7, 3);
    random_beats(60);
  endtask

  task automatic test_random_geometry();
    for (int p = 0; p < 10; p++) begin
      idling_on = (p % 4 != 3);
      if ($urandom_range(4) == 0)
        set_geometry($urandom_range(255), $urandom_range(255), $urandom_range(2047),
                     $urandom_range(2047), $urandom_range(7));
      else
        set_geometry($urandom_range(1, 16), $urandom_range(1, 16),
                     $urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 4));
      random_beats(100);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = gap_len();
    end
  end

  always @(posedge clk_i) begin
    resized_px_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px.size() == 0) begin
        $error("unexpected result beat: pixel_out %h", pixel_out_o);
        mismatches++;
      end else begin
        exp_px = pending_px.pop_front();
        if (pixel_out_o !== exp_px.pixel) begin
          $error("pixel_out expected %h actual %h", exp_px.pixel, pixel_out_o);
          mismatches++;
        end
        if (out_of_range_o !== exp_px.oor) begin
          $error("out_of_range expected %b actual %b", exp_px.oor, out_of_range_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    src_h_q = 128;
    src_w_q = 128;
    dst_h_q = 128;
    dst_w_q = 128;
    chans_q = 3;
    idling_on = 1'b0;
    mismatches = 0;
    stall_left = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_geometry();
    test_register_extremes();
    test_random_geometry();
    drain();
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[bilinear_image_resize.f]
rtl/bir_pkg.sv
rtl/bir_ram.sv
rtl/bir_div.sv
rtl/bilinear_image_resize.sv
sim/bilinear_image_resize_test.sv
